@@ rtl/core/assert_macros.svh @@
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

@@ rtl/core/ldc_pkg.sv @@
package ldc_pkg;

  localparam int unsigned CountBits = 24;
  localparam int unsigned LenBits = 24;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;
  localparam logic [LenBits-1:0] MaxLenReset = 24'h10_0000;
  localparam logic [LenBits-1:0] LenSat = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_CRC     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_CRC_ERR   = 2'd1,
    VERDICT_TOO_LONG  = 2'd2,
    VERDICT_TRUNCATED = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               byte_valid;
    logic               record_end;
    verdict_t           verdict;
    logic [LenBits-1:0] record_length;
  } result_t;

  typedef struct packed {
    logic halted;
    logic has_result;
  } parse_status_t;

  function automatic logic [LenBits-1:0] sat_len(input logic [31:0] v);
    logic [LenBits-1:0] r;
    r = (v > {8'h00, LenSat}) ? LenSat : v[LenBits-1:0];
    return r;
  endfunction

endpackage

@@ rtl/core/log_record_deframer_crc32_check_top.sv @@
// Log record deframer with CRC-32 check.
// Input channel: one log byte per transaction (data_byte, stream_end) on
// in_valid/in_ready. Records are a 4-byte little-endian length, a 4-byte
// little-endian CRC-32, then the payload.
// Output channel (out_valid/out_ready): each payload byte comes out with
// byte_valid set; the byte that completes a record also carries record_end,
// verdict and record_length. Header bytes that close nothing give no output.
// Throughput is one byte per clock unless the receiver stalls; the byte-wide
// CRC update and the length compare sit between the input register and the
// result register, which drives out_valid. A stalled receiver holds the
// result register; one more byte waits in the input register, then in_ready
// drops until the result is taken.
// cfg_wr_en/cfg_wr_data write max_record_length; write it only while idle.
// Reset sets max_record_length to 1048576, clears the parser to expect a
// length field and leaves no transaction pending. After the first bad or
// truncated record, or a stream end, later bytes are taken and dropped
// until the next reset.
`include "assert_macros.svh"

module log_record_deframer_crc32_check_top #(
  parameter int unsigned COUNT_BITS = ldc_pkg::CountBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ldc_pkg::LenBits-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        stream_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  payload_byte,
  output logic                        byte_valid,
  output logic                        record_end,
  output logic [1:0]                  verdict,
  output logic [ldc_pkg::LenBits-1:0] record_length
);
  import ldc_pkg::*;

  logic          in_q_valid, in_q_valid_next;
  logic [7:0]    in_q_byte;
  logic          in_q_end;
  logic          in_fire;
  logic          advance;
  logic          slot_free;
  result_t       res;
  result_t       res_q;
  parse_status_t status;

  assign in_fire  = in_valid && in_ready;
  assign advance  = in_q_valid && (slot_free || !status.has_result);
  assign in_ready = !in_q_valid || advance;

  always_comb begin
    in_q_valid_next = in_q_valid;
    if (in_fire) begin
      in_q_valid_next = 1'b1;
    end else if (advance) begin
      in_q_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= in_q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_q_byte <= data_byte;
      in_q_end  <= stream_end;
    end
  end

  ldc_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .data_byte   (in_q_byte),
    .stream_end  (in_q_end),
    .res         (res),
    .status      (status)
  );

  ldc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && status.has_result),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q),
    .slot_free (slot_free)
  );

  assign payload_byte  = res_q.payload_byte;
  assign byte_valid    = res_q.byte_valid;
  assign record_end    = res_q.record_end;
  assign verdict       = res_q.verdict;
  assign record_length = res_q.record_length;

  `ASSERT_NEVER(a_no_empty_result, clk, rst, out_valid && !byte_valid && !record_end, "result carries neither byte nor record end")
  `ASSERT_IMPLY(a_quiet_fields, clk, rst, out_valid && !record_end, verdict == VERDICT_OK && record_length == '0, "verdict or length set without record end")
  `ASSERT_IMPLY(a_bad_halts, clk, rst, out_valid && record_end && verdict != VERDICT_OK, status.halted, "parser still running after a bad record")
  `ASSERT_NEVER(a_halted_silent, clk, rst, status.halted && status.has_result, "result produced while halted")

endmodule

@@ rtl/core/ldc_crc8.sv @@
module ldc_crc8 (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);
  import ldc_pkg::*;

  logic [31:0] c;

  // reflected crc-32, one bit per step
  always_comb begin
    c = crc_in ^ {24'h00_0000, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

@@ rtl/core/ldc_parser.sv @@
module ldc_parser #(
  parameter int unsigned COUNT_BITS = ldc_pkg::CountBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ldc_pkg::LenBits-1:0] cfg_wr_data,
  input  logic                        advance,
  input  logic [7:0]                  data_byte,
  input  logic                        stream_end,
  output ldc_pkg::result_t            res,
  output ldc_pkg::parse_status_t      status
);
  import ldc_pkg::*;

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic [LenBits-1:0]    max_len;
  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] counter, counter_next, counter_inc;
  logic [31:0]           length_word, length_word_next;
  logic [31:0]           expected_crc, expected_crc_next;
  logic [31:0]           running_crc, running_crc_next;
  logic                  halted, halted_next;
  logic [31:0]           crc_upd;
  logic [31:0]           limit;
  logic                  has_result;
  logic [4:0]            lane_sel;

  ldc_crc8 u_crc8 (
    .crc_in  (running_crc),
    .data    (data_byte),
    .crc_out (crc_upd)
  );

  assign limit = ({8'h00, max_len} > CountMax) ? CountMax : {8'h00, max_len};
  assign counter_inc = counter + 1'b1;
  assign lane_sel = {counter[1:0], 3'b000};

  always_comb begin
    phase_next        = phase;
    counter_next      = counter;
    length_word_next  = length_word;
    expected_crc_next = expected_crc;
    running_crc_next  = running_crc;
    halted_next       = halted;
    res               = '0;
    has_result        = 1'b0;

    if (!halted) begin
      case (phase)
        PH_CRC: begin
          expected_crc_next[lane_sel +: 8] = data_byte;
          counter_next = counter_inc;
          if (counter[1:0] == 2'd3) begin
            if (length_word == 32'd0) begin
              // empty record closes on its last crc byte
              has_result     = 1'b1;
              res.record_end = 1'b1;
              res.verdict    = (expected_crc_next == (running_crc ^ CrcOnes)) ?
                               VERDICT_OK : VERDICT_CRC_ERR;
              if (res.verdict != VERDICT_OK || stream_end) halted_next = 1'b1;
              phase_next        = PH_LENGTH;
              counter_next      = '0;
              length_word_next  = '0;
              expected_crc_next = '0;
              running_crc_next  = CrcOnes;
            end else begin
              phase_next   = PH_PAYLOAD;
              counter_next = '0;
              if (stream_end) begin
                has_result        = 1'b1;
                res.record_end    = 1'b1;
                res.verdict       = VERDICT_TRUNCATED;
                res.record_length = sat_len(length_word);
                halted_next       = 1'b1;
              end
            end
          end else if (stream_end) begin
            has_result        = 1'b1;
            res.record_end    = 1'b1;
            res.verdict       = VERDICT_TRUNCATED;
            res.record_length = sat_len(length_word);
            halted_next       = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          has_result       = 1'b1;
          res.payload_byte = data_byte;
          res.byte_valid   = 1'b1;
          running_crc_next = crc_upd;
          counter_next     = counter_inc;
          if (32'(counter_inc) == length_word) begin
            res.record_end    = 1'b1;
            res.verdict       = ((crc_upd ^ CrcOnes) == expected_crc) ?
                                VERDICT_OK : VERDICT_CRC_ERR;
            res.record_length = sat_len(length_word);
            if (res.verdict != VERDICT_OK || stream_end) halted_next = 1'b1;
            phase_next        = PH_LENGTH;
            counter_next      = '0;
            length_word_next  = '0;
            expected_crc_next = '0;
            running_crc_next  = CrcOnes;
          end else if (stream_end) begin
            res.record_end    = 1'b1;
            res.verdict       = VERDICT_TRUNCATED;
            res.record_length = sat_len(length_word);
            halted_next       = 1'b1;
          end
        end
        default: begin
          // length bytes, also the unused phase code
          phase_next = PH_LENGTH;
          length_word_next[lane_sel +: 8] = data_byte;
          counter_next = counter_inc;
          if (counter[1:0] == 2'd3) begin
            if (length_word_next > limit) begin
              has_result        = 1'b1;
              res.record_end    = 1'b1;
              res.verdict       = VERDICT_TOO_LONG;
              res.record_length = sat_len(length_word_next);
              halted_next       = 1'b1;
            end else begin
              phase_next   = PH_CRC;
              counter_next = '0;
              if (stream_end) begin
                has_result        = 1'b1;
                res.record_end    = 1'b1;
                res.verdict       = VERDICT_TRUNCATED;
                res.record_length = sat_len(length_word_next);
                halted_next       = 1'b1;
              end
            end
          end else if (stream_end) begin
            has_result     = 1'b1;
            res.record_end = 1'b1;
            res.verdict    = VERDICT_TRUNCATED;
            halted_next    = 1'b1;
          end
        end
      endcase
    end
  end

  assign status.halted     = halted;
  assign status.has_result = has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= MaxLenReset;
      phase        <= PH_LENGTH;
      counter      <= '0;
      length_word  <= '0;
      expected_crc <= '0;
      running_crc  <= CrcOnes;
      halted       <= 1'b0;
    end else begin
      if (cfg_wr_en) max_len <= cfg_wr_data;
      if (advance) begin
        phase        <= phase_next;
        counter      <= counter_next;
        length_word  <= length_word_next;
        expected_crc <= expected_crc_next;
        running_crc  <= running_crc_next;
        halted       <= halted_next;
      end
    end
  end

endmodule

@@ rtl/core/ldc_out_stage.sv @@
module ldc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ldc_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output ldc_pkg::result_t res_q,
  output logic             slot_free
);
  import ldc_pkg::*;

  logic out_valid_next;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res_in;
  end

endmodule

@@ bench/log_record_deframer_crc32_check_checker.sv @@
`timescale 1ns / 1ps

module log_record_deframer_crc32_check_checker
  import ldc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LenBits-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         payload_byte,
  input  logic               byte_valid,
  input  logic               record_end,
  input  logic [1:0]         verdict,
  input  logic [LenBits-1:0] record_length,
  output int                 fail_count,
  output int                 pending
);

  // shadow of the parser state
  phase_t               stage;
  logic [CountBits-1:0] seen;
  logic [31:0]          declared_len;
  logic [31:0]          carried_crc;
  logic [31:0]          crc_acc;
  logic                 stopped;
  logic [LenBits-1:0]   max_len;

  result_t due_results[$];
  result_t want;
  int      mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    return v;
  endfunction

  function automatic logic [LenBits-1:0] clip_len(input logic [31:0] v);
    return (v > {8'd0, LenSat}) ? LenSat : v[LenBits-1:0];
  endfunction

  function automatic result_t closing(input verdict_t v, input logic [LenBits-1:0] len);
    result_t r;
    r = '0;
    r.record_end = 1'b1;
    r.verdict = v;
    r.record_length = len;
    return r;
  endfunction

  task automatic clear_record();
    stage = PH_LENGTH;
    seen = '0;
    declared_len = '0;
    carried_crc = '0;
    crc_acc = CrcOnes;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    result_t  r;
    logic     emit;
    verdict_t v;
    r = '0;
    emit = 1'b0;
    if (stopped) return;
    case (stage)
      PH_CRC: begin
        carried_crc = carried_crc | ({24'd0, b} << {seen[1:0], 3'b000});
        seen = seen + 1'b1;
        if (seen >= 4) begin
          if (declared_len == 0) begin
            // empty record closes on its last crc byte
            v = (~crc_acc == carried_crc) ? VERDICT_OK : VERDICT_CRC_ERR;
            r = closing(v, '0);
            emit = 1'b1;
            if (v != VERDICT_OK || last) stopped = 1'b1;
            clear_record();
          end else begin
            stage = PH_PAYLOAD;
            seen = '0;
            if (last) begin
              r = closing(VERDICT_TRUNCATED, clip_len(declared_len));
              emit = 1'b1;
              stopped = 1'b1;
            end
          end
        end else if (last) begin
          r = closing(VERDICT_TRUNCATED, clip_len(declared_len));
          emit = 1'b1;
          stopped = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        crc_acc = crc_update(crc_acc, b);
        seen = seen + 1'b1;
        if ({8'd0, seen} == declared_len) begin
          v = (~crc_acc == carried_crc) ? VERDICT_OK : VERDICT_CRC_ERR;
          r = closing(v, clip_len(declared_len));
          if (v != VERDICT_OK || last) stopped = 1'b1;
          clear_record();
        end else if (last) begin
          r = closing(VERDICT_TRUNCATED, clip_len(declared_len));
          stopped = 1'b1;
        end
        r.payload_byte = b;
        r.byte_valid = 1'b1;
        emit = 1'b1;
      end
      default: begin
        stage = PH_LENGTH;
        declared_len = declared_len | ({24'd0, b} << {seen[1:0], 3'b000});
        seen = seen + 1'b1;
        if (seen >= 4) begin
          // length check wins over a stream end on the same byte
          if (declared_len > {8'd0, max_len}) begin
            r = closing(VERDICT_TOO_LONG, clip_len(declared_len));
            emit = 1'b1;
            stopped = 1'b1;
          end else begin
            stage = PH_CRC;
            seen = '0;
            if (last) begin
              r = closing(VERDICT_TRUNCATED, clip_len(declared_len));
              emit = 1'b1;
              stopped = 1'b1;
            end
          end
        end else if (last) begin
          r = closing(VERDICT_TRUNCATED, '0);
          emit = 1'b1;
          stopped = 1'b1;
        end
      end
    endcase
    if (emit) due_results.insert(due_results.size(), r);
    else if (last && stage == PH_LENGTH && seen == 0) stopped = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      max_len = MaxLenReset;
      stopped = 1'b0;
      clear_record();
      due_results.delete();
    end else begin
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (in_valid && in_ready) deframe_byte(data_byte, stream_end);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual byte %0h bv %0b end %0b verdict %0d len %0d",
                   $time, payload_byte, byte_valid, record_end, verdict, record_length);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("byte_valid", want.byte_valid, byte_valid);
          check_field("record_end", want.record_end, record_end);
          check_field("verdict", want.verdict, verdict);
          check_field("record_length", want.record_length, record_length);
        end
      end
    end
    fail_count <= mismatches;
    pending <= due_results.size();
  end

endmodule

@@ bench/tb_log_record_deframer_crc32_check_top.sv @@
`timescale 1ns / 1ps

module tb_log_record_deframer_crc32_check_top;

  localparam int CycleLimit = 400000;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [ldc_pkg::LenBits-1:0] cfg_wr_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  data_byte;
  logic                        stream_end;
  logic                        out_valid;
  logic                        out_ready;
  logic [7:0]                  payload_byte;
  logic                        byte_valid;
  logic                        record_end;
  logic [1:0]                  verdict;
  logic [ldc_pkg::LenBits-1:0] record_length;
  int                          fail_count;
  int                          pending;

  int                          src_idle = 0;
  int                          snk_stall = 0;
  int                          items_sent = 0;
  int                          cycle_count = 0;
  logic [ldc_pkg::LenBits-1:0] cur_limit = ldc_pkg::MaxLenReset;
  logic [7:0]                  body_q[$];
  logic [7:0]                  frame_q[$];

  log_record_deframer_crc32_check_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .record_end   (record_end),
    .verdict      (verdict),
    .record_length(record_length)
  );

  log_record_deframer_crc32_check_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .record_end   (record_end),
    .verdict      (verdict),
    .record_length(record_length),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= snk_stall);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // crc of the payload used to build well-formed frames
  function automatic logic [31:0] frame_crc();
    logic [31:0] c;
    c = ldc_pkg::CrcOnes;
    foreach (body_q[i]) begin
      c = c ^ {24'd0, body_q[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ ldc_pkg::CrcPoly) : (c >> 1);
    end
    return c ^ ldc_pkg::CrcOnes;
  endfunction

  function automatic int pick_len(input logic [ldc_pkg::LenBits-1:0] lim);
    if (lim == 0) return 0;
    if (lim <= 40) return ($urandom_range(0, 2) == 0) ? int'(lim) : $urandom_range(0, lim);
    if ($urandom_range(0, 11) == 0) return $urandom_range(25, 80);
    return $urandom_range(0, 24);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    stream_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic fill_body(input int n);
    body_q.delete();
    repeat (n) body_q.insert(body_q.size(), 8'($urandom_range(0, 255)));
  endtask

  task automatic build_frame(input logic [31:0] len, input bit corrupt);
    logic [31:0] crc;
    crc = frame_crc();
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    frame_q.delete();
    for (int i = 0; i < 4; i++) frame_q.insert(frame_q.size(), len[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame_q.insert(frame_q.size(), crc[8*i +: 8]);
    foreach (body_q[i]) frame_q.insert(frame_q.size(), body_q[i]);
  endtask

  task automatic send_frame(input int upto, input int end_pos);
    for (int i = 0; i < upto; i++) push_byte(frame_q[i], i == end_pos);
  endtask

  task automatic send_record(input int n);
    fill_body(n);
    build_frame(n, 1'b0);
    send_frame(frame_q.size(), -1);
  endtask

  // hold off the sender until every transaction has drained out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ldc_pkg::LenBits-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cur_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [ldc_pkg::LenBits-1:0] lim, input int s_idle,
                           input int r_stall, input int budget);
    int target;
    write_limit(lim);
    src_idle = s_idle;
    snk_stall = r_stall;
    target = items_sent + budget;
    while (items_sent < target) send_record(pick_len(cur_limit));
  endtask

  initial begin
    int          kind;
    int          n;
    int          cut;
    logic [31:0] big;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    stream_end = 1'b0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty record, then extreme payload values, at the reset limit
    send_record(0);
    body_q = '{8'h00, 8'hFF};
    build_frame(2, 1'b0);
    send_frame(frame_q.size(), -1);

    run_phase(ldc_pkg::LenSat, 0, 0, 180);
    run_phase('0, 47, 0, 60);
    run_phase(24'($urandom_range(1, 40)), 0, 47, 150);
    run_phase(ldc_pkg::MaxLenReset, 35, 35, 150);

    // the stream can be stopped only once per run, so pick one way to end it
    kind = $urandom_range(0, 4);
    case (kind)
      0: begin
        n = $urandom_range(0, 10);
        fill_body(n);
        build_frame(n, 1'b0);
        cut = $urandom_range(0, 7);
        send_frame(cut + 1, cut);
      end
      1: begin
        n = $urandom_range(1, 20);
        fill_body(n);
        build_frame(n, 1'b0);
        cut = 8 + $urandom_range(0, n - 1);
        send_frame(cut + 1, cut);
      end
      2: begin
        fill_body($urandom_range(0, 20));
        build_frame(body_q.size(), 1'b0);
        send_frame(frame_q.size(), frame_q.size() - 1);
      end
      3: begin
        case ($urandom_range(0, 2))
          0: big = {8'd0, cur_limit} + 32'd1;
          1: big = 32'hFFFF_FFFF;
          default: big = 32'h0100_0000 + ($urandom & 32'h00FF_FFFF);
        endcase
        body_q.delete();
        build_frame(big, 1'b0);
        send_frame(4, $urandom_range(0, 1) ? 3 : -1);
      end
      default: begin
        fill_body($urandom_range(0, 20));
        build_frame(body_q.size(), 1'b1);
        send_frame(frame_q.size(), $urandom_range(0, 1) ? frame_q.size() - 1 : -1);
      end
    endcase

    // bytes after the stop must be swallowed
    repeat (12) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
